// ===== rtl/assert_macros.svh =====
// Assertion shorthands; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdh_pkg.sv =====
package pdh_pkg;

  // datapath widths
  localparam int ERR_W  = 13;
  localparam int DER_W  = 14;
  localparam int INT_W  = 32;
  localparam int ACC_W  = 41;            // |kp*e + ki*i + kd*d| < 2^40
  localparam int MAG_W  = ACC_W - 1;
  localparam int DVS_W  = 16;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  localparam logic [7:0] INTEGRATE_SPACING_DEF = 8'd1;
  localparam logic [7:0] HOLD_SPACING_DEF      = 8'd1;

  // register reset values
  localparam logic [11:0] SETPOINT_RST  = 12'(6000 / 3);
  localparam logic [7:0]  GAIN_P_RST    = 8'd30;
  localparam logic [7:0]  GAIN_I_RST    = 8'd4;
  localparam logic [7:0]  GAIN_D_RST    = 8'd20;
  localparam logic [15:0] DIVISOR_RST   = 16'd30;
  localparam logic [15:0] DRIVE_MAX_RST = 16'd270;
  localparam logic [7:0]  DRIVE_MIN_RST = 8'd0;
  localparam logic [7:0]  DEADBAND_RST  = 8'd4;

  // register indexes
  localparam logic [2:0] REG_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_GAIN_P    = 3'd1;
  localparam logic [2:0] REG_GAIN_I    = 3'd2;
  localparam logic [2:0] REG_GAIN_D    = 3'd3;
  localparam logic [2:0] REG_DIVISOR   = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd5;
  localparam logic [2:0] REG_DRIVE_MIN = 3'd6;
  localparam logic [2:0] REG_DEADBAND  = 3'd7;

  typedef struct packed {
    logic [11:0] setpoint;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [15:0] divisor;
    logic [15:0] drive_max;
    logic [7:0]  drive_min;
    logic [7:0]  deadband;
  } cfg_t;

  // microprogram addresses
  typedef logic [3:0] step_t;
  localparam step_t P_IDLE  = 4'd0;
  localparam step_t P_ERR   = 4'd1;
  localparam step_t P_STATE = 4'd2;
  localparam step_t P_MUL_P = 4'd3;
  localparam step_t P_MUL_I = 4'd4;
  localparam step_t P_MUL_D = 4'd5;
  localparam step_t P_SUM   = 4'd6;
  localparam step_t P_DIV   = 4'd7;
  localparam step_t P_DIVW  = 4'd8;
  localparam step_t P_CLAMP = 4'd9;
  localparam step_t P_OUT   = 4'd10;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_P    = 2'd1,
    MUL_I    = 2'd2,
    MUL_D    = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  // stay on the current step while the condition holds
  typedef enum logic [1:0] {
    H_NONE  = 2'd0,
    H_NO_IN = 2'd1,
    H_DIV   = 2'd2,
    H_OUT   = 2'd3
  } hold_t;

  typedef struct packed {
    logic     load_in;
    logic     err_load;
    logic     state_upd;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_start;
    logic     drive_load;
    logic     out_write;
  } ctrl_t;

  typedef struct packed {
    hold_t hold;
    step_t next;
    ctrl_t ctl;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_busy;
  } seq_status_t;

  function automatic ucode_t ucode(step_t step);
    ucode_t w;
    w = '0;
    w.next = P_IDLE;
    unique case (step)
      P_IDLE: begin
        w.hold = H_NO_IN;
        w.next = P_ERR;
        w.ctl.load_in = 1'b1;
      end
      P_ERR: begin
        w.next = P_STATE;
        w.ctl.err_load = 1'b1;
      end
      P_STATE: begin
        w.next = P_MUL_P;
        w.ctl.state_upd = 1'b1;
      end
      P_MUL_P: begin
        w.next = P_MUL_I;
        w.ctl.mul_sel = MUL_P;
      end
      P_MUL_I: begin
        w.next = P_MUL_D;
        w.ctl.mul_sel = MUL_I;
        w.ctl.acc_op = ACC_LOAD;
      end
      P_MUL_D: begin
        w.next = P_SUM;
        w.ctl.mul_sel = MUL_D;
        w.ctl.acc_op = ACC_ADD;
      end
      P_SUM: begin
        w.next = P_DIV;
        w.ctl.acc_op = ACC_ADD;
      end
      P_DIV: begin
        w.next = P_DIVW;
        w.ctl.div_start = 1'b1;
      end
      P_DIVW: begin
        w.hold = H_DIV;
        w.next = P_CLAMP;
      end
      P_CLAMP: begin
        w.next = P_OUT;
        w.ctl.drive_load = 1'b1;
      end
      P_OUT: begin
        w.hold = H_OUT;
        w.next = P_IDLE;
        w.ctl.out_write = 1'b1;
      end
      default: w.next = P_IDLE;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pid_heater_drive.sv =====
// PID heater drive with anti-windup.
// Input channel: in_valid / in_stall carry one filtered ADC reading
// (measured_level) per transaction. Output channel: out_valid / out_stall
// carry the clamped PWM duty (drive) and the deadbanded error (error).
// Config port: cfg_we writes cfg_wdata into register cfg_index
// (0 setpoint, 1 gain_p, 2 gain_i, 3 gain_d, 4 divisor, 5 drive_max,
// 6 drive_min, 7 deadband); the user must write only while no transaction
// is in flight; the block itself does not enforce it.
// Timing: one reading at a time, taken only on the idle step. The program
// then runs error load, state update, the three gain products, sum, divide
// start, divide wait (held while a restoring divide retires one of 40
// quotient bits per cycle), clamp and output write. The next reading is
// taken on the idle step that follows the result write.
// A stalled result holds in the output register; the next reading is still
// taken and worked on, and the program waits on its last step until the
// register frees up.
// Reset (rst, synchronous): registers return to defaults, integral, held
// error, step counters and last drive clear, the program restarts idle.
`include "assert_macros.svh"

module pid_heater_drive #(
  parameter logic [7:0] INTEGRATE_SPACING = pdh_pkg::INTEGRATE_SPACING_DEF,
  parameter logic [7:0] HOLD_SPACING      = pdh_pkg::HOLD_SPACING_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        measured_level,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        drive,
  output logic signed [12:0] error
);

  pdh_pkg::cfg_t        cfg;
  pdh_pkg::step_t       step;
  pdh_pkg::ctrl_t       ctrl;
  pdh_pkg::seq_status_t status;

  logic                              div_busy;
  logic [pdh_pkg::MAG_W-1:0]         quotient;
  logic [pdh_pkg::MAG_W-1:0]         div_dividend;
  logic [pdh_pkg::DVS_W-1:0]         div_divisor;
  logic signed [pdh_pkg::ERR_W-1:0]  err_value;
  logic [15:0]                       drive_value;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint  <= pdh_pkg::SETPOINT_RST;
      cfg.gain_p    <= pdh_pkg::GAIN_P_RST;
      cfg.gain_i    <= pdh_pkg::GAIN_I_RST;
      cfg.gain_d    <= pdh_pkg::GAIN_D_RST;
      cfg.divisor   <= pdh_pkg::DIVISOR_RST;
      cfg.drive_max <= pdh_pkg::DRIVE_MAX_RST;
      cfg.drive_min <= pdh_pkg::DRIVE_MIN_RST;
      cfg.deadband  <= pdh_pkg::DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdh_pkg::REG_SETPOINT:  cfg.setpoint  <= cfg_wdata[11:0];
        pdh_pkg::REG_GAIN_P:    cfg.gain_p    <= cfg_wdata[7:0];
        pdh_pkg::REG_GAIN_I:    cfg.gain_i    <= cfg_wdata[7:0];
        pdh_pkg::REG_GAIN_D:    cfg.gain_d    <= cfg_wdata[7:0];
        pdh_pkg::REG_DIVISOR:   cfg.divisor   <= cfg_wdata;
        pdh_pkg::REG_DRIVE_MAX: cfg.drive_max <= cfg_wdata;
        pdh_pkg::REG_DRIVE_MIN: cfg.drive_min <= cfg_wdata[7:0];
        pdh_pkg::REG_DEADBAND:  cfg.deadband  <= cfg_wdata[7:0];
        default:                cfg           <= cfg;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: the idle step is the only one that takes a reading
  // ---------------------------------------------------------------------
  assign in_stall        = step != pdh_pkg::P_IDLE;
  assign status.in_valid = in_valid;
  assign status.div_busy = div_busy;
  assign status.out_busy = out_valid && out_stall;

  pdh_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .step   (step),
    .ctrl   (ctrl)
  );

  pdh_datapath #(
    .INTEGRATE_SPACING (INTEGRATE_SPACING),
    .HOLD_SPACING      (HOLD_SPACING)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cfg            (cfg),
    .measured_level (measured_level),
    .quotient       (quotient),
    .div_dividend   (div_dividend),
    .div_divisor    (div_divisor),
    .err_value      (err_value),
    .drive_value    (drive_value)
  );

  pdh_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------------
  // Output register: decouples the program from a stalled receiver
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_write) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_write) begin
      drive <= drive_value;
      error <= err_value;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_NEXT(a_in_starts_program, in_valid && !in_stall, step == pdh_pkg::P_ERR, "input transaction did not start the program")
  `ASSERT_IMPLIES(a_div_in_wait_step, div_busy, step == pdh_pkg::P_DIVW, "divider busy outside its wait step")
  `ASSERT_IMPLIES(a_out_from_write_step, $rose(out_valid), $past(step) == pdh_pkg::P_OUT, "result appeared outside the write step")
  `ASSERT_IMPLIES(a_drive_in_limits, out_valid, drive <= cfg.drive_max || drive == 16'(cfg.drive_min), "drive outside clamp limits")

endmodule

// ===== rtl/pdh_sequencer.sv =====
module pdh_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  pdh_pkg::seq_status_t status,
  output pdh_pkg::step_t      step,
  output pdh_pkg::ctrl_t      ctrl
);

  pdh_pkg::ucode_t word;
  pdh_pkg::step_t  step_next;
  logic            hold;

  assign word = pdh_pkg::ucode(step);

  always_comb begin
    unique case (word.hold)
      pdh_pkg::H_NONE:  hold = 1'b0;
      pdh_pkg::H_NO_IN: hold = !status.in_valid;
      pdh_pkg::H_DIV:   hold = status.div_busy;
      pdh_pkg::H_OUT:   hold = status.out_busy;
      default:          hold = 1'b0;
    endcase
  end

  // actions fire only on the cycle the step is left
  assign step_next = hold ? step : word.next;
  assign ctrl      = hold ? '0 : word.ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= pdh_pkg::P_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/pdh_divider.sv =====
module pdh_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pdh_pkg::MAG_W-1:0]   dividend,
  input  logic [pdh_pkg::DVS_W-1:0]   divisor,
  output logic                        busy,
  output logic [pdh_pkg::MAG_W-1:0]   quotient
);

  logic [pdh_pkg::DVS_W-1:0] rem;
  logic [pdh_pkg::DVS_W:0]   shifted;
  logic                      ge;
  logic [pdh_pkg::DVS_W:0]   diff;
  logic [pdh_pkg::CNT_W-1:0] cnt;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quotient[pdh_pkg::MAG_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= pdh_pkg::CNT_W'(pdh_pkg::MAG_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != pdh_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[pdh_pkg::DVS_W-1:0] : shifted[pdh_pkg::DVS_W-1:0];
      quotient <= {quotient[pdh_pkg::MAG_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/pdh_datapath.sv =====
module pdh_datapath #(
  parameter logic [7:0] INTEGRATE_SPACING = pdh_pkg::INTEGRATE_SPACING_DEF,
  parameter logic [7:0] HOLD_SPACING      = pdh_pkg::HOLD_SPACING_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pdh_pkg::ctrl_t                    ctrl,
  input  pdh_pkg::cfg_t                     cfg,
  input  logic [11:0]                       measured_level,
  input  logic [pdh_pkg::MAG_W-1:0]         quotient,
  output logic [pdh_pkg::MAG_W-1:0]         div_dividend,
  output logic [pdh_pkg::DVS_W-1:0]         div_divisor,
  output logic signed [pdh_pkg::ERR_W-1:0]  err_value,
  output logic [15:0]                       drive_value
);

  logic [11:0]                        level;
  logic signed [pdh_pkg::ERR_W-1:0]   err_raw;
  logic [pdh_pkg::ERR_W-1:0]          err_mag;
  logic signed [pdh_pkg::ERR_W-1:0]   err_db;
  logic signed [pdh_pkg::ERR_W-1:0]   held;
  logic signed [pdh_pkg::DER_W-1:0]   deriv;
  logic signed [pdh_pkg::INT_W-1:0]   integral;
  logic signed [pdh_pkg::INT_W:0]     int_sum;
  logic signed [pdh_pkg::INT_W-1:0]   int_sat;
  logic [7:0]                         int_count;
  logic [7:0]                         hold_count;
  logic                               int_fire;
  logic                               hold_fire;
  logic                               at_limit;
  logic [15:0]                        last_drive;
  logic [7:0]                         mul_g;
  logic signed [pdh_pkg::INT_W-1:0]   mul_b;
  logic signed [pdh_pkg::ACC_W-1:0]   prod_full;
  logic signed [pdh_pkg::ACC_W-1:0]   prod;
  logic signed [pdh_pkg::ACC_W-1:0]   acc;
  logic signed [pdh_pkg::ACC_W-1:0]   acc_abs;
  logic                               q_neg;
  logic [15:0]                        q_hi;
  logic [15:0]                        drive_next;

  // deadbanded error
  assign err_raw = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, level});
  assign err_mag = err_raw[pdh_pkg::ERR_W-1] ? 13'(-err_raw) : 13'(err_raw);
  assign err_db  = (err_mag < {5'b0, cfg.deadband}) ? '0 : err_raw;

  // saturating integral update
  assign int_sum = {integral[pdh_pkg::INT_W-1], integral}
                 + {{(pdh_pkg::INT_W + 1 - pdh_pkg::ERR_W){err_value[pdh_pkg::ERR_W-1]}},
                    err_value};
  always_comb begin
    if (int_sum[pdh_pkg::INT_W] != int_sum[pdh_pkg::INT_W-1]) begin
      int_sat = int_sum[pdh_pkg::INT_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      int_sat = int_sum[pdh_pkg::INT_W-1:0];
    end
  end

  assign int_fire  = int_count == INTEGRATE_SPACING;
  assign hold_fire = hold_count == HOLD_SPACING;
  assign at_limit  = (last_drive == cfg.drive_max) || (last_drive == {8'b0, cfg.drive_min});

  // shared 9x32 signed multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      pdh_pkg::MUL_P: begin
        mul_g = cfg.gain_p;
        mul_b = {{(pdh_pkg::INT_W - pdh_pkg::ERR_W){err_value[pdh_pkg::ERR_W-1]}}, err_value};
      end
      pdh_pkg::MUL_I: begin
        mul_g = cfg.gain_i;
        mul_b = integral;
      end
      pdh_pkg::MUL_D: begin
        mul_g = cfg.gain_d;
        mul_b = {{(pdh_pkg::INT_W - pdh_pkg::DER_W){deriv[pdh_pkg::DER_W-1]}}, deriv};
      end
      default: begin
        mul_g = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_full = $signed({1'b0, mul_g}) * mul_b;

  // divider operands: magnitude of the sum, and the divisor with zero taken as one
  assign acc_abs      = acc[pdh_pkg::ACC_W-1] ? -acc : acc;
  assign div_dividend = acc_abs[pdh_pkg::MAG_W-1:0];
  assign div_divisor  = (cfg.divisor == '0) ? 16'd1 : cfg.divisor;

  // clamp; upper limit first, then lower
  always_comb begin
    q_hi = (quotient > {24'b0, cfg.drive_max}) ? cfg.drive_max : quotient[15:0];
    if (q_neg && (quotient != '0)) begin
      drive_next = {8'b0, cfg.drive_min};
    end else if (q_hi < {8'b0, cfg.drive_min}) begin
      drive_next = {8'b0, cfg.drive_min};
    end else begin
      drive_next = q_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      held       <= '0;
      int_count  <= '0;
      hold_count <= '0;
      last_drive <= '0;
    end else begin
      if (ctrl.state_upd) begin
        int_count  <= int_fire ? 8'd0 : int_count + 8'd1;
        hold_count <= hold_fire ? 8'd0 : hold_count + 8'd1;
        if (int_fire && !at_limit) begin
          integral <= int_sat;
        end
        if (hold_fire) begin
          held <= err_value;
        end
      end
      if (ctrl.out_write) begin
        last_drive <= drive_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      level <= measured_level;
    end
    if (ctrl.err_load) begin
      err_value <= err_db;
    end
    if (ctrl.state_upd) begin
      deriv <= {err_value[pdh_pkg::ERR_W-1], err_value} - {held[pdh_pkg::ERR_W-1], held};
    end
    if (ctrl.mul_sel != pdh_pkg::MUL_NONE) begin
      prod <= prod_full;
    end
    case (ctrl.acc_op)
      pdh_pkg::ACC_LOAD: acc <= prod;
      pdh_pkg::ACC_ADD:  acc <= acc + prod;
      default:           acc <= acc;
    endcase
    if (ctrl.div_start) begin
      q_neg <= acc[pdh_pkg::ACC_W-1];
    end
    if (ctrl.drive_load) begin
      drive_value <= drive_next;
    end
  end

endmodule
